### src/kst_pkg.sv
// Package of types and constants for the keyed slot table.
`default_nettype none
package kst_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned CntW = $clog2(Slots + 1);

  typedef enum logic [2:0] {
    CmdInsert = 3'd0,
    CmdDelete = 3'd1,
    CmdUpdate = 3'd2,
    CmdMin    = 3'd3,
    CmdMax    = 3'd4,
    CmdSortUp = 3'd5,
    CmdSortDn = 3'd6,
    CmdRead   = 3'd7
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;     // latch the request
    logic       scan_clr; // restart a scan at slot zero
    logic       scan_en;  // examine one slot, advance
    logic       sort_clr; // restart sort walk
    logic       sort_en;  // one compare/exchange step
    logic       finish;   // form the result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic sort_last;
    logic is_sort;
  } dp_stat_t;
endpackage
`default_nettype wire

### src/kst_ctrl.sv
// Controller state machine for the keyed slot table.
`default_nettype none
module kst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  output kst_pkg::dp_cmd_t       cmd_o,
  input  wire kst_pkg::dp_stat_t stat_i
);
  import kst_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StSort = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   mv_q, mv_d;

  // Free to accept when idle and the output register is empty or draining.
  assign s_ready_o = (state_q == StIdle) && (!mv_q || m_ready_i);
  assign m_valid_o = mv_q;

  always_comb begin
    state_d = state_q;
    mv_d    = mv_q && !m_ready_i;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (s_valid_i && s_ready_o) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          cmd_o.sort_clr = 1'b1;
          state_d        = StScan;
        end
      end
      StScan: begin
        if (stat_i.is_sort) begin
          state_d = StSort;
        end else begin
          cmd_o.scan_en = 1'b1;
          if (stat_i.scan_last) state_d = StDone;
        end
      end
      StSort: begin
        cmd_o.sort_en = 1'b1;
        if (stat_i.sort_last) state_d = StDone;
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        mv_d         = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mv_q    <= mv_d;
    end
  end

  // Result only raised when the previous one has gone.
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> (!mv_q || m_ready_i)) else $error("result overrun");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_ready_o |-> (state_q == StIdle)) else $error("ready while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> m_valid_o) else $error("result lost");
endmodule
`default_nettype wire

### src/kst_dp.sv
// Datapath of the keyed slot table: slot storage, scan and sort walks.
`default_nettype none
module kst_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [55:0]            s_tdata_i,
  output logic [57:0]                 m_tdata_o,
  input  wire kst_pkg::dp_cmd_t       cmd_i,
  output kst_pkg::dp_stat_t           stat_o
);
  import kst_pkg::*;

  logic [Slots-1:0] valid_q;
  logic [15:0]      key_q [Slots];
  logic [31:0]      val_q [Slots];

  // latched request
  cmd_e        op_q;
  logic [15:0] rkey_q;
  logic [31:0] rval_q;
  logic [3:0]  ridx_q;

  logic [SlotW-1:0] sc_q;       // scan position
  logic [SlotW-1:0] si_q, sj_q; // sort pair
  logic             found_q;
  logic [SlotW-1:0] hit_q;
  logic [15:0]      hkey_q;
  logic [31:0]      hval_q;
  logic [CntW-1:0]  occ_q;
  logic [57:0]      res_q;

  logic vi, vj, swap, hit;
  logic [15:0] ck;
  logic [31:0] cv;
  logic cvalid;
  assign ck     = key_q[sc_q];
  assign cv     = val_q[sc_q];
  assign cvalid = valid_q[sc_q];
  assign vi     = valid_q[si_q];
  assign vj     = valid_q[sj_q];
  assign swap   = vi && vj && ((op_q == CmdSortDn) ? (val_q[si_q] < val_q[sj_q])
                                                  : (val_q[si_q] > val_q[sj_q]));

  // Per-slot decision of the current scan step.
  always_comb begin
    hit = 1'b0;
    case (op_q)
      CmdInsert: hit = !cvalid && !found_q;
      CmdDelete: hit = cvalid && (ck == rkey_q);
      CmdUpdate: hit = cvalid && (ck == rkey_q) && !found_q;
      CmdMin:    hit = cvalid && (!found_q || cv < hval_q);
      CmdMax:    hit = cvalid && (!found_q || cv > hval_q);
      default:   hit = 1'b0;
    endcase
  end

  assign stat_o.scan_last = (sc_q == SlotW'(Slots - 1));
  assign stat_o.sort_last = (si_q == SlotW'(Slots - 2)) && (sj_q == SlotW'(Slots - 1));
  assign stat_o.is_sort   = (op_q == CmdSortUp) || (op_q == CmdSortDn);

  // Control registers: valid marks, walk counters, occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      sc_q    <= '0;
      si_q    <= '0;
      sj_q    <= '0;
      found_q <= 1'b0;
      occ_q   <= '0;
    end else begin
      if (cmd_i.scan_clr) begin
        sc_q    <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.sort_clr) begin
        si_q <= '0;
        sj_q <= SlotW'(1);
      end
      if (cmd_i.scan_en) begin
        sc_q <= sc_q + 1'b1;
        if (hit) begin
          found_q <= 1'b1;
          if (op_q == CmdInsert) begin
            valid_q[sc_q] <= 1'b1;
            occ_q         <= occ_q + 1'b1;
          end
          if (op_q == CmdDelete) begin
            valid_q[sc_q] <= 1'b0;
            occ_q         <= occ_q - 1'b1;
          end
        end
      end
      if (cmd_i.sort_en) begin
        if (sj_q == SlotW'(Slots - 1)) begin
          si_q <= si_q + 1'b1;
          sj_q <= si_q + SlotW'(2);
        end else begin
          sj_q <= sj_q + 1'b1;
        end
      end
    end
  end

  // Payload registers: request, slot contents, hit capture, result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= cmd_e'(s_tdata_i[2:0]);
      rkey_q <= s_tdata_i[18:3];
      rval_q <= s_tdata_i[50:19];
      ridx_q <= s_tdata_i[54:51];
    end
    if (cmd_i.scan_en && hit && !(op_q == CmdDelete && found_q)) begin
      hit_q  <= sc_q;
      hkey_q <= (op_q == CmdInsert) ? rkey_q : ck;
      hval_q <= (op_q == CmdInsert || op_q == CmdUpdate) ? rval_q : cv;
    end
    if (cmd_i.scan_en && hit && (op_q == CmdInsert)) begin
      key_q[sc_q] <= rkey_q;
      val_q[sc_q] <= rval_q;
    end
    if (cmd_i.scan_en && hit && (op_q == CmdUpdate)) val_q[sc_q] <= rval_q;
    if (cmd_i.sort_en && swap) begin
      key_q[si_q] <= key_q[sj_q];
      val_q[si_q] <= val_q[sj_q];
      key_q[sj_q] <= key_q[si_q];
      val_q[sj_q] <= val_q[si_q];
    end
    if (cmd_i.finish) begin
      case (op_q)
        CmdSortUp, CmdSortDn: res_q <= {CntW'(occ_q), 4'd0, 32'd0, 16'd0, 1'b1};
        CmdRead: begin
          if (valid_q[ridx_q[SlotW-1:0]])
            res_q <= {occ_q, ridx_q, val_q[ridx_q[SlotW-1:0]],
                      key_q[ridx_q[SlotW-1:0]], 1'b1};
          else
            res_q <= {occ_q, ridx_q, 32'd0, 16'd0, 1'b0};
        end
        default: begin
          if (found_q) res_q <= {occ_q, 4'(hit_q), hval_q, hkey_q, 1'b1};
          else         res_q <= {occ_q, 4'd0, 32'd0, 16'd0, 1'b0};
        end
      endcase
    end
  end

  assign m_tdata_o = res_q;

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(Slots)) else $error("occupancy out of range");
  a_occ_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == CntW'($countones(valid_q))) else $error("occupancy mismatch");
  a_sort_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sort_en |-> (si_q < sj_q)) else $error("sort pair order");
endmodule
`default_nettype wire

### src/keyed_slot_table_core.sv
// Top level of the keyed slot table.
// A 16-slot keyed table. Each request takes one result. Insert, delete,
// update, min, max and read walk the slots one per cycle before the
// result is formed. Sorts pass through the scan state for decode and then
// step the exchange-sort pair walk, one pair per cycle (120 pairs), before
// the result is formed. The next request can be taken in the same cycle as
// the result is raised, when the result is taken at once.
`default_nettype none
module keyed_slot_table_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // cmd, key, value, slot_index, zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // ok, out_key, out_value, out_slot, occupied, pad
);
  import kst_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [57:0] res;

  kst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_valid_i (s_axis_tvalid), .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid), .m_ready_i (m_axis_tready),
    .cmd_o (cmd), .stat_i (stat)
  );

  kst_dp u_dp (
    .clk_i, .rst_ni,
    .s_tdata_i (s_axis_tdata), .m_tdata_o (res),
    .cmd_i (cmd), .stat_o (stat)
  );

  assign m_axis_tdata = {6'd0, res};
endmodule
`default_nettype wire
